### rtl/core/hssc_pkg.sv
package hssc_pkg;

    localparam int TIME_W  = 48;
    localparam int TICKS_W = 32;

    localparam logic [2:0]  HALL_RESET_PATTERN  = 3'd1;
    localparam logic [31:0] STALL_TIMEOUT_RESET = 32'd500000;

    localparam logic signed [1:0] DIR_NONE    = 2'sd0;
    localparam logic signed [1:0] DIR_FORWARD = 2'sd1;
    localparam logic signed [1:0] DIR_REVERSE = -2'sd1;

    typedef enum logic [1:0] {
        CMD_SAMPLE      = 2'd0,
        CMD_RESET       = 2'd1,
        CMD_STALL_CHECK = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_STEP    = 2'd0,
        ST_INVALID = 2'd1,
        ST_GLITCH  = 2'd2,
        ST_OTHER   = 2'd3
    } status_t;

    // Per-motor tracking state
    typedef struct packed {
        logic [2:0]                prev_pattern;
        logic signed [TICKS_W-1:0] ticks;
        logic signed [1:0]         direction;
        logic [TIME_W-1:0]         last_us;
        logic                      stalled;
    } motor_state_t;

    // Forward successor in the sequence 1,3,2,6,4,5
    function automatic logic [2:0] succ_fwd(input logic [2:0] pat);
        logic [2:0] res;
        unique case (pat)
            3'd1:    res = 3'd3;
            3'd2:    res = 3'd6;
            3'd3:    res = 3'd2;
            3'd4:    res = 3'd5;
            3'd5:    res = 3'd1;
            3'd6:    res = 3'd4;
            default: res = 3'd0;
        endcase
        return res;
    endfunction

    // Reverse successor in the sequence 1,5,4,6,2,3
    function automatic logic [2:0] succ_rev(input logic [2:0] pat);
        logic [2:0] res;
        unique case (pat)
            3'd1:    res = 3'd5;
            3'd2:    res = 3'd3;
            3'd3:    res = 3'd1;
            3'd4:    res = 3'd6;
            3'd5:    res = 3'd4;
            3'd6:    res = 3'd2;
            default: res = 3'd0;
        endcase
        return res;
    endfunction

endpackage

### rtl/core/hssc_step_logic.sv
module hssc_step_logic
    import hssc_pkg::*;
(
    input  logic [1:0]        cmd,
    input  logic [2:0]        hall_pattern,
    input  logic [TIME_W-1:0] now_us,
    input  logic [31:0]       timeout_us,
    input  motor_state_t      cur,
    output motor_state_t      nxt,
    output status_t           status
);

    logic [TIME_W-1:0] elapsed;
    logic              pat_invalid;
    logic              is_fwd;
    logic              is_rev;

    // Decode the transition against the previous pattern
    assign pat_invalid = (hall_pattern == 3'd0) || (hall_pattern == 3'd7);
    assign is_fwd      = (succ_fwd(cur.prev_pattern) == hall_pattern);
    assign is_rev      = (succ_rev(cur.prev_pattern) == hall_pattern);
    assign elapsed     = now_us - cur.last_us;

    always_comb
    begin
        nxt    = cur;
        status = ST_OTHER;
        unique case (cmd)
            CMD_SAMPLE:
            begin
                nxt.prev_pattern = hall_pattern;
                priority if (pat_invalid)
                begin
                    status = ST_INVALID;
                end
                else if (is_fwd)
                begin
                    nxt.ticks     = cur.ticks + 32'sd1;
                    nxt.direction = DIR_FORWARD;
                    nxt.last_us   = now_us;
                    nxt.stalled   = 1'b0;
                    status        = ST_STEP;
                end
                else if (is_rev)
                begin
                    nxt.ticks     = cur.ticks - 32'sd1;
                    nxt.direction = DIR_REVERSE;
                    nxt.last_us   = now_us;
                    nxt.stalled   = 1'b0;
                    status        = ST_STEP;
                end
                else
                begin
                    status = ST_GLITCH;
                end
            end
            CMD_RESET:
            begin
                nxt.ticks     = '0;
                nxt.direction = DIR_NONE;
                nxt.last_us   = now_us;
                nxt.stalled   = 1'b0;
            end
            CMD_STALL_CHECK:
            begin
                if ((cur.last_us != '0) && (elapsed > {16'd0, timeout_us}))
                begin
                    nxt.stalled = 1'b1;
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

### rtl/core/hall_sensor_step_counter.sv
// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_stall    cmd, motor, hall_pattern, now_us
// result    out        out_valid / out_stall  out_motor, ticks, direction,
//                                             last_step_us, stalled, status
// config    in         cfg_valid / cfg_ready  cfg_timeout
//
// A result is registered after its input transaction: the input register
// feeds one pass of the step logic into the result register and motor state.
// One item per cycle unless out_stall is set; motor state updates as an item
// leaves the input register, so items for the same motor follow back to back.
// Reset restores pattern 1, zero counters and the default stall timeout.
// A stalled result holds a full input register, which raises in_stall.
module hall_sensor_step_counter
    import hssc_pkg::*;
#(
    parameter int MOTOR_COUNT = 2
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                cmd,
    input  logic                      motor,
    input  logic [2:0]                hall_pattern,
    input  logic [TIME_W-1:0]         now_us,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      out_motor,
    output logic signed [TICKS_W-1:0] ticks,
    output logic signed [1:0]         direction,
    output logic [TIME_W-1:0]         last_step_us,
    output logic                      stalled,
    output logic [1:0]                status,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [31:0]               cfg_timeout
);

    logic [31:0]              timeout_reg;
    logic                     s0_valid_reg;
    logic [1:0]               s0_cmd_reg;
    logic                     s0_motor_reg;
    logic [2:0]               s0_pattern_reg;
    logic [TIME_W-1:0]        s0_now_reg;
    motor_state_t             state_reg [MOTOR_COUNT];
    logic [MOTOR_COUNT-1:0]   motor_sel;
    logic                     motor_hit;
    motor_state_t             cur_state;
    motor_state_t             nxt_state;
    status_t                  step_status;
    logic                     out_free;
    logic                     s0_adv;
    logic                     out_valid_reg;
    logic                     out_motor_reg;
    logic signed [TICKS_W-1:0] out_ticks_reg;
    logic signed [1:0]        out_dir_reg;
    logic [TIME_W-1:0]        out_last_reg;
    logic                     out_stalled_reg;
    logic [1:0]               out_status_reg;

    // Handshake: the input register moves whenever the result register frees
    assign out_free  = !out_valid_reg || !out_stall;
    assign s0_adv    = s0_valid_reg && out_free;
    assign in_stall  = s0_valid_reg && !out_free;
    assign cfg_ready = 1'b1;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= STALL_TIMEOUT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            timeout_reg <= cfg_timeout;
        end
    end

    // Input register: control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s0_valid_reg <= in_valid;
        end
    end

    // Input register: payload
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s0_cmd_reg     <= cmd;
            s0_motor_reg   <= motor;
            s0_pattern_reg <= hall_pattern;
            s0_now_reg     <= now_us;
        end
    end

    // Select the addressed motor's state
    always_comb
    begin
        cur_state = '0;
        motor_sel = '0;
        for (int m = 0; m < MOTOR_COUNT; m++)
        begin
            if (32'(s0_motor_reg) == 32'(m))
            begin
                motor_sel[m] = 1'b1;
                cur_state    = state_reg[m];
            end
        end
    end

    assign motor_hit = |motor_sel;

    hssc_step_logic u_step (
        .cmd          (s0_cmd_reg),
        .hall_pattern (s0_pattern_reg),
        .now_us       (s0_now_reg),
        .timeout_us   (timeout_reg),
        .cur          (cur_state),
        .nxt          (nxt_state),
        .status       (step_status)
    );

    // Motor state: write back as the item leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int m = 0; m < MOTOR_COUNT; m++)
            begin
                state_reg[m].prev_pattern <= HALL_RESET_PATTERN;
                state_reg[m].ticks        <= '0;
                state_reg[m].direction    <= DIR_NONE;
                state_reg[m].last_us      <= '0;
                state_reg[m].stalled      <= 1'b0;
            end
        end
        else if (s0_adv)
        begin
            for (int m = 0; m < MOTOR_COUNT; m++)
            begin
                if (motor_sel[m])
                begin
                    state_reg[m] <= nxt_state;
                end
            end
        end
    end

    // Result register: control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s0_valid_reg;
        end
    end

    // Result register: payload, zeros and ST_OTHER status for a motor outside the array
    always_ff @(posedge clk)
    begin
        if (s0_adv)
        begin
            out_motor_reg <= s0_motor_reg;
            if (motor_hit)
            begin
                out_ticks_reg   <= nxt_state.ticks;
                out_dir_reg     <= nxt_state.direction;
                out_last_reg    <= nxt_state.last_us;
                out_stalled_reg <= nxt_state.stalled;
                out_status_reg  <= step_status;
            end
            else
            begin
                out_ticks_reg   <= '0;
                out_dir_reg     <= DIR_NONE;
                out_last_reg    <= '0;
                out_stalled_reg <= 1'b0;
                out_status_reg  <= ST_OTHER;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_motor    = out_motor_reg;
    assign ticks        = out_ticks_reg;
    assign direction    = out_dir_reg;
    assign last_step_us = out_last_reg;
    assign stalled      = out_stalled_reg;
    assign status       = out_status_reg;

`ifndef NO_ASSERTIONS
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s0_valid_reg)
        else $error("in_stall raised with an empty input register");

    a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s0_valid_reg))
        else $error("result appeared without an item in the input register");

    a_step_has_dir: assert property (@(posedge clk) disable iff (!rst_n)
        (s0_adv && motor_hit && step_status == ST_STEP) |=>
        (out_dir_reg == DIR_FORWARD || out_dir_reg == DIR_REVERSE))
        else $error("counted step reported without a direction");

    a_step_clears_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s0_adv && motor_hit && step_status == ST_STEP) |=> !out_stalled_reg)
        else $error("counted step left the stall flag set");

    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready) |=> timeout_reg == $past(cfg_timeout))
        else $error("stall timeout not loaded by a configuration transaction");
`endif

endmodule

### tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import hssc_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Hall successor tables, three bits per entry, entry n at bits 3n+2:3n
    localparam logic [23:0] FWD_NEXT = {3'd0, 3'd4, 3'd1, 3'd5, 3'd2, 3'd6, 3'd3, 3'd0};
    localparam logic [23:0] REV_NEXT = {3'd0, 3'd2, 3'd4, 3'd6, 3'd1, 3'd3, 3'd5, 3'd0};

    localparam int HOLD_CYCLES    = 64;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic                      motor;
        logic signed [TICKS_W-1:0] ticks;
        logic signed [1:0]         dir;
        logic [TIME_W-1:0]         last_us;
        logic                      stalled;
        status_t                   st;
    } motor_report_t;

    // Tracks per-motor hall state and checks the reported motor state in order
    class step_scoreboard;
        logic [2:0]                prev_pat [2];
        logic signed [TICKS_W-1:0] tick_cnt [2];
        logic signed [1:0]         dir      [2];
        logic [TIME_W-1:0]         last_us  [2];
        logic                      stall    [2];
        logic [31:0]               timeout;
        motor_report_t             expected_reports [$];
        int                        errors;

        function new();
            for (int m = 0; m < 2; m++)
            begin
                prev_pat[m] = HALL_RESET_PATTERN;
                tick_cnt[m] = '0;
                dir[m]      = DIR_NONE;
                last_us[m]  = '0;
                stall[m]    = 1'b0;
            end
            timeout = STALL_TIMEOUT_RESET;
            errors  = 0;
        endfunction

        // Predict the report for one accepted command transaction
        function void note_command(logic [1:0] c, logic m, logic [2:0] pat,
                                   logic [TIME_W-1:0] now);
            motor_report_t     rep;
            logic [TIME_W-1:0] elapsed;
            rep.st = ST_OTHER;
            case (c)
                CMD_SAMPLE:
                begin
                    if (pat == 3'd0 || pat == 3'd7)
                        rep.st = ST_INVALID;
                    else if (FWD_NEXT[3*prev_pat[m] +: 3] == pat)
                    begin
                        tick_cnt[m] = tick_cnt[m] + 1;
                        dir[m]      = DIR_FORWARD;
                        last_us[m]  = now;
                        stall[m]    = 1'b0;
                        rep.st      = ST_STEP;
                    end
                    else if (REV_NEXT[3*prev_pat[m] +: 3] == pat)
                    begin
                        tick_cnt[m] = tick_cnt[m] - 1;
                        dir[m]      = DIR_REVERSE;
                        last_us[m]  = now;
                        stall[m]    = 1'b0;
                        rep.st      = ST_STEP;
                    end
                    else
                        rep.st = ST_GLITCH;
                    prev_pat[m] = pat;
                end
                CMD_RESET:
                begin
                    tick_cnt[m] = '0;
                    dir[m]      = DIR_NONE;
                    last_us[m]  = now;
                    stall[m]    = 1'b0;
                end
                CMD_STALL_CHECK:
                begin
                    // Elapsed time wraps at the 48-bit boundary
                    elapsed = now - last_us[m];
                    if (last_us[m] != '0 && elapsed > {16'd0, timeout})
                        stall[m] = 1'b1;
                end
                default: ;
            endcase
            rep.motor   = m;
            rep.ticks   = tick_cnt[m];
            rep.dir     = dir[m];
            rep.last_us = last_us[m];
            rep.stalled = stall[m];
            expected_reports.push_back(rep);
        endfunction

        // Compare one result transaction with the oldest expected report
        function void check_report(motor_report_t act);
            motor_report_t exp_r;
            if (expected_reports.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result: motor=%0d ticks=%0d", act.motor, act.ticks);
                return;
            end
            exp_r = expected_reports.pop_front();
            if (act.motor !== exp_r.motor || act.ticks !== exp_r.ticks ||
                act.dir !== exp_r.dir || act.last_us !== exp_r.last_us ||
                act.stalled !== exp_r.stalled || act.st !== exp_r.st)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                begin
                    $display("expected motor=%0d ticks=%0d dir=%0d last=%0h stall=%0b st=%0d",
                             exp_r.motor, exp_r.ticks, exp_r.dir, exp_r.last_us,
                             exp_r.stalled, exp_r.st);
                    $display("actual   motor=%0d ticks=%0d dir=%0d last=%0h stall=%0b st=%0d",
                             act.motor, act.ticks, act.dir, act.last_us,
                             act.stalled, act.st);
                end
            end
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n            = 1'b0;
    logic                      in_valid         = 1'b0;
    logic                      in_stall;
    logic [1:0]                cmd              = '0;
    logic                      motor            = 1'b0;
    logic [2:0]                hall_pattern     = '0;
    logic [TIME_W-1:0]         now_us           = '0;
    logic                      out_valid;
    logic                      out_stall        = 1'b0;
    logic                      out_motor;
    logic signed [TICKS_W-1:0] ticks;
    logic signed [1:0]         direction;
    logic [TIME_W-1:0]         last_step_us;
    logic                      stalled;
    logic [1:0]                status;
    logic                      cfg_valid        = 1'b0;
    logic                      cfg_ready;
    logic [31:0]               cfg_timeout      = STALL_TIMEOUT_RESET;

    step_scoreboard    sb;
    int                idle_pct     = 0;
    int                stall_pct    = 0;
    int                step_span    = 1000;
    int                quiet_cycles = 0;
    int                hold_left    = 0;
    bit                hold_request = 1'b0;
    logic [TIME_W-1:0] clock_us     = '0;

    hall_sensor_step_counter #(
        .MOTOR_COUNT(2)
    ) i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .cmd              (cmd),
        .motor            (motor),
        .hall_pattern     (hall_pattern),
        .now_us           (now_us),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .out_motor        (out_motor),
        .ticks            (ticks),
        .direction        (direction),
        .last_step_us     (last_step_us),
        .stalled          (stalled),
        .status           (status),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_timeout      (cfg_timeout)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Observe all three channels and guard against a hang
    always @(posedge clk)
    begin : monitor
        motor_report_t seen;
        bit            progress;
        progress = 1'b0;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                seen.motor   = out_motor;
                seen.ticks   = ticks;
                seen.dir     = direction;
                seen.last_us = last_step_us;
                seen.stalled = stalled;
                seen.st      = status_t'(status);
                sb.check_report(seen);
                progress = 1'b1;
            end
            if (in_valid && !in_stall)
            begin
                sb.note_command(cmd, motor, hall_pattern, now_us);
                progress = 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                sb.timeout = cfg_timeout;
                progress   = 1'b1;
            end
            quiet_cycles = progress ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Result side: random stalls, plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Present one command and hold it until the transaction completes; call at negedge
    task automatic offer(input logic [1:0] c, input logic m, input logic [2:0] pat,
                         input logic [TIME_W-1:0] now);
        in_valid     <= 1'b1;
        cmd          <= c;
        motor        <= m;
        hall_pattern <= pat;
        now_us       <= now;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // Drop valid for a random number of cycles
    task automatic idle_gap();
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
    endtask

    // Stop offering until every expected report has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_timeout(input logic [31:0] value);
        wait_drained();
        repeat (2) @(negedge clk);
        cfg_valid   <= 1'b1;
        cfg_timeout <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Build a command, mostly well-formed hall steps from the tracked pattern
    task automatic random_item();
        logic [1:0]        c;
        logic              m;
        logic [2:0]        pat;
        logic [2:0]        prev;
        logic [TIME_W-1:0] now;
        int                r;
        m = 1'($urandom_range(1, 0));
        r = $urandom_range(99);
        if (r < 78)
            c = CMD_SAMPLE;
        else if (r < 88)
            c = CMD_STALL_CHECK;
        else if (r < 95)
            c = CMD_RESET;
        else
            c = CMD_UNUSED;

        // Advance the time base: small steps, big jumps, a fresh value, or no change
        r = $urandom_range(99);
        if (r < 65)
            clock_us = clock_us + $urandom_range(step_span, 0);
        else if (r < 75)
            clock_us = clock_us + TIME_W'({$urandom, $urandom});
        else if (r < 80)
            clock_us = TIME_W'({$urandom, $urandom});
        now = clock_us;

        prev = sb.prev_pat[m];
        r    = $urandom_range(99);
        if (c != CMD_SAMPLE)
            pat = 3'($urandom_range(7, 0));
        else if (r < 55 && FWD_NEXT[3*prev +: 3] != 3'd0)
            pat = FWD_NEXT[3*prev +: 3];
        else if (r < 75 && REV_NEXT[3*prev +: 3] != 3'd0)
            pat = REV_NEXT[3*prev +: 3];
        else if (r < 90)
            pat = 3'($urandom_range(6, 1));
        else
            pat = $urandom_range(1, 0) ? 3'd7 : 3'd0;

        if (c == CMD_RESET && $urandom_range(99) < 20)
            now = '0;
        offer(c, m, pat, now);
    endtask

    task automatic run_phase(input logic [31:0] timeout, input int idle, input int stall,
                             input int count, input int span, input bit hold_mid,
                             input bit drain_mid);
        write_timeout(timeout);
        idle_pct  = idle;
        stall_pct = stall;
        step_span = span;
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 2 && hold_mid)
                hold_request = 1'b1;
            if (i == count / 2 && drain_mid)
                wait_drained();
            idle_gap();
            random_item();
        end
    endtask

    initial
    begin
        sb = new();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: successors both ways, invalid and glitch patterns, time extremes
        offer(CMD_STALL_CHECK, 1'b0, 3'd0, 48'd1000);
        offer(CMD_SAMPLE,      1'b0, 3'd3, 48'd0);
        offer(CMD_STALL_CHECK, 1'b0, 3'd7, 48'hFFFF_FFFF_FFFF);
        offer(CMD_SAMPLE,      1'b0, 3'd2, 48'd100);
        offer(CMD_SAMPLE,      1'b0, 3'd3, 48'd200);
        offer(CMD_SAMPLE,      1'b0, 3'd7, 48'd300);
        offer(CMD_SAMPLE,      1'b0, 3'd1, 48'd400);
        offer(CMD_SAMPLE,      1'b0, 3'd0, 48'd500);
        offer(CMD_SAMPLE,      1'b0, 3'd5, 48'd600);
        offer(CMD_SAMPLE,      1'b0, 3'd4, 48'hFFFF_FFFF_FFFF);
        offer(CMD_STALL_CHECK, 1'b0, 3'd0, 48'd5);
        offer(CMD_STALL_CHECK, 1'b0, 3'd0, 48'd500000);
        offer(CMD_SAMPLE,      1'b0, 3'd6, 48'd500010);
        offer(CMD_SAMPLE,      1'b1, 3'd5, 48'h8000_0000_0000);
        offer(CMD_SAMPLE,      1'b1, 3'd6, 48'h8000_0000_0100);
        offer(CMD_UNUSED,      1'b1, 3'd7, 48'h7FFF_FFFF_FFFF);
        offer(CMD_RESET,       1'b0, 3'd0, 48'h8000_0000_0000);
        offer(CMD_STALL_CHECK, 1'b0, 3'd0, 48'h8000_0007_A120);
        offer(CMD_STALL_CHECK, 1'b0, 3'd0, 48'h8000_0007_A121);
        offer(CMD_RESET,       1'b1, 3'd0, 48'd0);
        offer(CMD_STALL_CHECK, 1'b1, 3'd0, 48'hFFFF_FFFF_FFFF);

        // Random phases across timeout settings and handshake pressure
        run_phase(32'd1,                              0,  0,  200, 4,     1'b1, 1'b0);
        run_phase(32'hFFFF_FFFF,                      78, 0,  200, 20000, 1'b0, 1'b1);
        run_phase($urandom_range(5000, 1),            0,  78, 250, 8000,  1'b0, 1'b0);
        run_phase($urandom_range(32'hFFFF_FFFF, 1),   31, 31, 280, 20000, 1'b0, 1'b0);

        // Let the pipeline empty, then report
        wait_drained();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### sim.f
rtl/core/hssc_pkg.sv
rtl/core/hssc_step_logic.sv
rtl/core/hall_sensor_step_counter.sv
tb/tb_top.sv
